### sv/conv2d_kxk_padded_top_defines.svh
// conv2d_kxk_padded_top_defines.svh
// Assertion macros for the K x K convolution RTL; no dependencies.
// The macros expect i_clk and i_rst_n in the scope where they are used.
`ifndef CONV2D_KXK_PADDED_TOP_DEFINES_SVH
`define CONV2D_KXK_PADDED_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define C2K_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define C2K_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define C2K_ASSERT(name, prop, msg)
`define C2K_ASSERT_RST(name, prop, msg)
`endif
`endif

### sv/c2k_pkg.sv
// c2k_pkg.sv
// Shared constants, codes and pipeline control type for the K x K convolution.
// No dependencies.
`timescale 1ns / 1ps
package c2k_pkg;
    localparam int DEF_MAX_KERNEL = 5;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT     = 4096;

    localparam int PIX_W      = 16;
    localparam int PROD_W     = 32;
    localparam int OUT_W      = 36;
    localparam int X_W        = 11;
    localparam int Y_W        = 12;
    localparam int OW_W       = 12;
    localparam int OH_W       = 13;
    localparam int K_W        = 3;
    localparam int WIDX_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 64;

    typedef enum logic {
        OP_WEIGHT = 1'b0,
        OP_PIXEL  = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUT_WIDTH   = 2'd0,
        REG_OUT_HEIGHT  = 2'd1,
        REG_KERNEL_SIZE = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic adv_ab;
        logic adv_bc;
        logic adv_cd;
        logic adv_de;
        logic adv_ef;
    } t_ctl;
endpackage

### sv/c2k_line_buf.sv
// c2k_line_buf.sv
// Row memories: one slot per recent padded row, registered reads.
// Depends on c2k_pkg.
`timescale 1ns / 1ps
module c2k_line_buf #(
    parameter int MAX_KERNEL = c2k_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH  = c2k_pkg::DEF_MAX_WIDTH,
    localparam int SW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
    localparam int AW = $clog2(MAX_WIDTH + MAX_KERNEL)
) (
    input  logic                             i_clk,
    input  c2k_pkg::t_ctl                    i_ctl,
    input  logic                             i_wr_en,
    input  logic [SW-1:0]                    i_slot,
    input  logic [AW-1:0]                    i_addr,
    input  logic signed [c2k_pkg::PIX_W-1:0] i_pix,
    output logic signed [c2k_pkg::PIX_W-1:0] o_rd [MAX_KERNEL]
);
    import c2k_pkg::*;

    localparam int DEPTH = MAX_WIDTH + MAX_KERNEL;

    for (genvar g = 0; g < MAX_KERNEL; g++) begin : g_slot
        logic signed [PIX_W-1:0] mem [DEPTH];
        logic signed [PIX_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv_ab && i_wr_en && (i_slot == SW'(g))) begin
                mem[i_addr] <= i_pix;
            end
            if (i_ctl.adv_ab) begin
                r_rd <= mem[i_addr];
            end
        end

        assign o_rd[g] = r_rd;
    end
endmodule

### sv/c2k_window.sv
// c2k_window.sv
// Sliding K x K window, kernel weight store and the registered tap products.
// Depends on c2k_pkg.
`timescale 1ns / 1ps
module c2k_window #(
    parameter int MAX_KERNEL = c2k_pkg::DEF_MAX_KERNEL,
    localparam int SW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
    localparam int NTAPS = MAX_KERNEL * MAX_KERNEL,
    localparam int TW    = (NTAPS > 1) ? $clog2(NTAPS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  c2k_pkg::t_ctl                     i_ctl,
    input  logic                              i_shift,
    input  logic signed [c2k_pkg::PIX_W-1:0]  i_pix,
    input  logic [SW-1:0]                     i_slot,
    input  logic signed [c2k_pkg::PIX_W-1:0]  i_rd [MAX_KERNEL],
    input  logic                              i_w_en,
    input  logic [c2k_pkg::WIDX_W-1:0]        i_w_idx,
    input  logic signed [c2k_pkg::PIX_W-1:0]  i_w_val,
    input  logic [c2k_pkg::K_W-1:0]           i_k,
    output logic signed [c2k_pkg::PROD_W-1:0] o_prod [MAX_KERNEL][MAX_KERNEL]
);
    import c2k_pkg::*;

    logic signed [PIX_W-1:0]  r_wt   [NTAPS];
    logic signed [PIX_W-1:0]  r_win  [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0] r_prod [MAX_KERNEL][MAX_KERNEL];
    logic signed [PIX_W-1:0]  new_col [MAX_KERNEL];
    logic signed [PIX_W-1:0]  w_sel  [MAX_KERNEL][MAX_KERNEL];
    logic [SW:0]              sel    [MAX_KERNEL];

    // Row d back from the newest row lives in slot (slot - d) mod MAX_KERNEL.
    always_comb begin
        for (int d = 0; d < MAX_KERNEL; d++) begin
            sel[d] = (SW+1)'(i_slot) + (SW+1)'(MAX_KERNEL - d);
            if (sel[d] >= (SW+1)'(MAX_KERNEL)) begin
                sel[d] = sel[d] - (SW+1)'(MAX_KERNEL);
            end
            new_col[d] = (d == 0) ? i_pix : i_rd[sel[d][SW-1:0]];
        end
    end

    always_comb begin
        for (int d = 0; d < MAX_KERNEL; d++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
                w_sel[d][j] = '0;
                for (int kk = 1; kk <= MAX_KERNEL; kk++) begin
                    if (int'(i_k) == kk && d < kk && j < kk) begin
                        w_sel[d][j] = r_wt[TW'((kk - 1 - d) * kk + (kk - 1 - j))];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NTAPS; t++) begin
                r_wt[t] <= '0;
            end
        end else if (i_ctl.adv_cd && i_w_en && (int'(i_w_idx) < NTAPS)) begin
            r_wt[TW'(i_w_idx)] <= i_w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_bc && i_shift) begin
            for (int d = 0; d < MAX_KERNEL; d++) begin
                r_win[d][0] <= new_col[d];
                for (int j = 1; j < MAX_KERNEL; j++) begin
                    r_win[d][j] <= r_win[d][j-1];
                end
            end
        end
        if (i_ctl.adv_cd) begin
            for (int d = 0; d < MAX_KERNEL; d++) begin
                for (int j = 0; j < MAX_KERNEL; j++) begin
                    // drop taps outside the K x K window
                    if (d < int'(i_k) && j < int'(i_k)) begin
                        r_prod[d][j] <= PROD_W'(r_win[d][j]) * PROD_W'(w_sel[d][j]);
                    end else begin
                        r_prod[d][j] <= '0;
                    end
                end
            end
        end
    end

    assign o_prod = r_prod;
endmodule

### sv/c2k_sum.sv
// c2k_sum.sv
// Two-level registered adder tree: per-row sums, then the window sum.
// Depends on c2k_pkg.
`timescale 1ns / 1ps
module c2k_sum #(
    parameter int MAX_KERNEL = c2k_pkg::DEF_MAX_KERNEL
) (
    input  logic                              i_clk,
    input  c2k_pkg::t_ctl                     i_ctl,
    input  logic signed [c2k_pkg::PROD_W-1:0] i_prod [MAX_KERNEL][MAX_KERNEL],
    output logic signed [c2k_pkg::OUT_W-1:0]  o_sum
);
    import c2k_pkg::*;

    localparam int ROW_W = PROD_W + $clog2(MAX_KERNEL + 1);
    localparam int SUM_W = ROW_W + $clog2(MAX_KERNEL + 1);

    logic signed [ROW_W-1:0] r_row [MAX_KERNEL];
    logic signed [ROW_W-1:0] n_row [MAX_KERNEL];
    logic signed [SUM_W-1:0] n_sum;
    logic signed [OUT_W-1:0] r_sum;

    always_comb begin
        for (int d = 0; d < MAX_KERNEL; d++) begin
            n_row[d] = '0;
            for (int j = 0; j < MAX_KERNEL; j++) begin
                n_row[d] = n_row[d] + ROW_W'(i_prod[d][j]);
            end
        end
        n_sum = '0;
        for (int d = 0; d < MAX_KERNEL; d++) begin
            n_sum = n_sum + SUM_W'(r_row[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_de) begin
            r_row <= n_row;
        end
        if (i_ctl.adv_ef) begin
            r_sum <= OUT_W'(n_sum);
        end
    end

    assign o_sum = r_sum;
endmodule

### sv/conv2d_kxk_padded_top.sv
// conv2d_kxk_padded_top.sv
// Streaming K x K convolution over a pre-padded raster image.
// Depends on c2k_pkg, c2k_line_buf, c2k_window, c2k_sum and the defines header.
`timescale 1ns / 1ps
`include "conv2d_kxk_padded_top_defines.svh"
// The block takes one item per clock, weight load or pixel, and returns the result
// for the pixel that completes a window through stages a to f; it stalls only when the
// result port is held. The rate is set by the row memories: MAX_KERNEL memories
// of MAX_WIDTH+MAX_KERNEL words, each with one write and one registered read per
// cycle, a parallel multiplier per window tap and a two-level adder tree. No
// clearing pass runs after reset. Weights take effect for pixels that follow them.
module conv2d_kxk_padded_top #(
    parameter int MAX_KERNEL = c2k_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH  = c2k_pkg::DEF_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [c2k_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [c2k_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // weight_index[4:0], value[20:5], zero fill above
    input  logic [c2k_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    // opcode[0]
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // out_value[35:0], out_x[46:36], out_y[58:47], zero fill above
    output logic [c2k_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);
    import c2k_pkg::*;

    localparam int SW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int CW = $clog2(MAX_WIDTH + MAX_KERNEL);

    // configuration
    logic [OW_W-1:0] r_cfg_w;
    logic [OH_W-1:0] r_cfg_h;
    logic [K_W-1:0]  r_cfg_k;
    logic [CW-1:0]   w_c, stride;
    logic [OH_W-1:0] h_c, rows;
    logic [K_W-1:0]  k_c, k1, pad;

    // frame position
    logic [CW-1:0]   r_col, n_col;
    logic [OH_W-1:0] r_row, n_row;
    logic [SW-1:0]   r_slot, n_slot;

    // item fields and window decision
    t_opcode                 in_op;
    logic                    acc;
    logic                    res;
    logic [X_W-1:0]          res_x;
    logic [Y_W-1:0]          res_y;
    logic                    res_last;

    // pipeline stages
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
    t_ctl ctl;

    t_opcode                 r_a_op, r_b_op, r_c_op;
    logic [WIDX_W-1:0]       r_a_idx, r_b_idx, r_c_idx;
    logic signed [PIX_W-1:0] r_a_val, r_b_val, r_c_val;
    logic [CW-1:0]           r_a_col;
    logic [SW-1:0]           r_a_slot, r_b_slot;
    logic                    r_a_res, r_b_res, r_c_res;
    logic [X_W-1:0]          r_a_x, r_b_x, r_c_x, r_d_x, r_e_x, r_f_x;
    logic [Y_W-1:0]          r_a_y, r_b_y, r_c_y, r_d_y, r_e_y, r_f_y;
    logic                    r_a_last, r_b_last, r_c_last, r_d_last, r_e_last, r_f_last;

    logic signed [PIX_W-1:0]  rd_data [MAX_KERNEL];
    logic signed [PROD_W-1:0] prod    [MAX_KERNEL][MAX_KERNEL];
    logic signed [OUT_W-1:0]  sum;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_c = CW'(1);
        end else if ((OW_W+1)'(r_cfg_w) > (OW_W+1)'(MAX_WIDTH)) begin
            w_c = CW'(MAX_WIDTH);
        end else begin
            w_c = CW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_c = OH_W'(1);
        end else if (r_cfg_h > OH_W'(MAX_HEIGHT)) begin
            h_c = OH_W'(MAX_HEIGHT);
        end else begin
            h_c = r_cfg_h;
        end
        if (r_cfg_k == '0) begin
            k_c = K_W'(1);
        end else if (r_cfg_k > K_W'(MAX_KERNEL)) begin
            k_c = K_W'(MAX_KERNEL);
        end else begin
            k_c = r_cfg_k;
        end
        k1     = k_c - K_W'(1);
        pad    = k_c >> 1;
        stride = w_c + (CW'(pad) << 1);
        rows   = h_c + (OH_W'(pad) << 1);
    end

    // handshake chain: a stage loads when empty or when it empties this cycle
    always_comb begin
        rdy_f      = !r_f_v || i_m_axis_tready;
        rdy_e      = !r_e_v || rdy_f;
        rdy_d      = !r_d_v || rdy_e;
        rdy_c      = !r_c_v || rdy_d;
        rdy_b      = !r_b_v || rdy_c;
        rdy_a      = !r_a_v || rdy_b;
        ctl.adv_ab = r_a_v && rdy_b;
        ctl.adv_bc = r_b_v && rdy_c;
        ctl.adv_cd = r_c_v && rdy_d;
        ctl.adv_de = r_d_v && rdy_e;
        ctl.adv_ef = r_e_v && rdy_f;
    end

    assign o_s_axis_tready = rdy_a;
    assign acc             = i_s_axis_tvalid && rdy_a;
    assign in_op           = t_opcode'(i_s_axis_tuser);

    always_comb begin
        res = (r_row >= OH_W'(k1)) && (r_row < h_c + OH_W'(k1))
            && (r_col >= CW'(k1)) && (r_col < w_c + CW'(k1));
        res_x    = X_W'(r_col - CW'(k1));
        res_y    = Y_W'(r_row - OH_W'(k1));
        res_last = ((r_row - OH_W'(k1)) == (h_c - OH_W'(1)))
                && ((r_col - CW'(k1)) == (w_c - CW'(1)));
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_slot = r_slot;
        if (acc && in_op == OP_PIXEL) begin
            n_col = r_col + CW'(1);
            if (n_col >= stride) begin
                n_col  = '0;
                n_row  = r_row + OH_W'(1);
                n_slot = (r_slot == SW'(MAX_KERNEL - 1)) ? '0 : r_slot + SW'(1);
                if (n_row >= rows) begin
                    n_row  = '0;
                    n_slot = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= OW_W'(2048);
            r_cfg_h <= OH_W'(2048);
            r_cfg_k <= K_W'(3);
            r_col   <= '0;
            r_row   <= '0;
            r_slot  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_OUT_WIDTH: begin
                    r_cfg_w <= i_cfg_wdata[OW_W-1:0];
                    r_col   <= '0;
                    r_row   <= '0;
                    r_slot  <= '0;
                end
                REG_OUT_HEIGHT: begin
                    r_cfg_h <= i_cfg_wdata[OH_W-1:0];
                    r_col   <= '0;
                    r_row   <= '0;
                    r_slot  <= '0;
                end
                REG_KERNEL_SIZE: begin
                    r_cfg_k <= i_cfg_wdata[K_W-1:0];
                    r_col   <= '0;
                    r_row   <= '0;
                    r_slot  <= '0;
                end
                default: begin
                    r_col  <= n_col;
                    r_row  <= n_row;
                    r_slot <= n_slot;
                end
            endcase
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_v <= acc;
            end
            if (rdy_b) begin
                r_b_v <= r_a_v;
            end
            if (rdy_c) begin
                r_c_v <= r_b_v;
            end
            if (rdy_d) begin
                r_d_v <= r_c_v && r_c_res && (r_c_op == OP_PIXEL);
            end
            if (rdy_e) begin
                r_e_v <= r_d_v;
            end
            if (rdy_f) begin
                r_f_v <= r_e_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_op   <= in_op;
            r_a_idx  <= i_s_axis_tdata[WIDX_W-1:0];
            r_a_val  <= i_s_axis_tdata[WIDX_W+PIX_W-1:WIDX_W];
            r_a_col  <= r_col;
            r_a_slot <= r_slot;
            r_a_res  <= res && (in_op == OP_PIXEL);
            r_a_x    <= res_x;
            r_a_y    <= res_y;
            r_a_last <= res_last;
        end
        if (rdy_b) begin
            r_b_op   <= r_a_op;
            r_b_idx  <= r_a_idx;
            r_b_val  <= r_a_val;
            r_b_slot <= r_a_slot;
            r_b_res  <= r_a_res;
            r_b_x    <= r_a_x;
            r_b_y    <= r_a_y;
            r_b_last <= r_a_last;
        end
        if (rdy_c) begin
            r_c_op   <= r_b_op;
            r_c_idx  <= r_b_idx;
            r_c_val  <= r_b_val;
            r_c_res  <= r_b_res;
            r_c_x    <= r_b_x;
            r_c_y    <= r_b_y;
            r_c_last <= r_b_last;
        end
        if (rdy_d) begin
            r_d_x    <= r_c_x;
            r_d_y    <= r_c_y;
            r_d_last <= r_c_last;
        end
        if (rdy_e) begin
            r_e_x    <= r_d_x;
            r_e_y    <= r_d_y;
            r_e_last <= r_d_last;
        end
        if (rdy_f) begin
            r_f_x    <= r_e_x;
            r_f_y    <= r_e_y;
            r_f_last <= r_e_last;
        end
    end

    c2k_line_buf #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_wr_en (r_a_op == OP_PIXEL),
        .i_slot  (r_a_slot),
        .i_addr  (r_a_col),
        .i_pix   (r_a_val),
        .o_rd    (rd_data)
    );

    c2k_window #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_shift (r_b_op == OP_PIXEL),
        .i_pix   (r_b_val),
        .i_slot  (r_b_slot),
        .i_rd    (rd_data),
        .i_w_en  (r_c_op == OP_WEIGHT),
        .i_w_idx (r_c_idx),
        .i_w_val (r_c_val),
        .i_k     (k_c),
        .o_prod  (prod)
    );

    c2k_sum #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_sum (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_prod (prod),
        .o_sum  (sum)
    );

    assign o_m_axis_tvalid = r_f_v;
    assign o_m_axis_tdata  = {(M_TDATA_W - OUT_W - X_W - Y_W)'(0), r_f_y, r_f_x, sum};
    assign o_m_axis_tlast  = r_f_last;

    `C2K_ASSERT(a_col_in_row, r_col < stride, "column count beyond padded row")
    `C2K_ASSERT(a_row_in_frame, r_row < rows, "row count beyond padded frame")
    `C2K_ASSERT(a_slot_range, r_slot < SW'(MAX_KERNEL), "row slot out of range")
    `C2K_ASSERT_RST(a_rst_pos, !i_rst_n |=> (r_col == '0 && r_row == '0 && r_slot == '0), "frame position not cleared by reset")
endmodule
